// File: src/siq_pkg.sv
// shared types and constants for the sorted insert priority queue
// no dependencies; imported by the interfaces, the cell and the top level
package siq_pkg;

  // number of cells in the sorted chain
  localparam int CAPACITY  = 16;
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int DATA_W    = 32;
  localparam int KIND_W    = 2;
  localparam int OUT_CNT_W = 5;

  // operation codes
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_POP    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FIND   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd3;

  // broadcast to every cell for one request
  typedef struct packed {
    logic                     ins_en;
    logic                     pop_en;
    logic signed [DATA_W-1:0] value;
  } siq_ctl_t;

  // what one cell reports back to the chain
  typedef struct packed {
    logic ge;
    logic eq;
  } siq_stat_t;

endpackage

// File: src/siq_if.sv
// valid/ready channel interfaces for request and result items
// depends on siq_pkg
interface siq_in_if import siq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, kind, value, input ready);
  modport sink   (input valid, kind, value, output ready);
endinterface

interface siq_out_if import siq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     ok;
  logic signed [DATA_W-1:0] result_value;
  logic [OUT_CNT_W-1:0]     count;

  modport source (output valid, ok, result_value, count, input ready);
  modport sink   (input valid, ok, result_value, count, output ready);
endinterface

// File: src/sorted_insert_priority_queue_top.sv
// sorted insert priority queue: a chain of CAPACITY cells plus count and result register
// depends on siq_pkg, siq_if and siq_cell
//
//  channel  | dir | payload                       | handshake
//  in_ch    | in  | kind, value                   | valid/ready
//  out_ch   | out | ok, result_value, count       | valid/ready
//
// all cells compare against the value of a request in parallel and shift in the
// same edge; the result is registered and appears in the cycle after acceptance.
// one request per cycle is taken while the result register is empty or drained.
// a stalled result holds the input off; the chain itself never waits.
// synchronous active-low reset clears the count and the result valid; entries
// are left as they are and only cells below the count are ever read.
module sorted_insert_priority_queue_top import siq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  siq_in_if.sink     in_ch,
  siq_out_if.source  out_ch
);

  logic [CNT_W-1:0]         count_r;
  logic [CNT_W-1:0]         count_nxt;
  logic                     out_valid_r;
  logic                     out_ok_r;
  logic                     out_ok_nxt;
  logic signed [DATA_W-1:0] out_value_r;
  logic signed [DATA_W-1:0] out_value_nxt;
  logic [OUT_CNT_W-1:0]     out_count_r;

  logic                     accept;
  logic                     empty;
  logic                     full;
  logic                     found;
  siq_ctl_t                 ctl;
  logic signed [DATA_W-1:0] entry   [CAPACITY];
  siq_stat_t                stat    [CAPACITY];
  logic [CAPACITY-1:0]      occ;
  logic [CAPACITY-1:0]      eq_vec;

  // handshake: take a request whenever the result slot frees this cycle
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign empty       = (count_r == '0);
  assign full        = (count_r == CNT_W'(CAPACITY));

  // broadcast control
  assign ctl.ins_en = accept && (in_ch.kind == KIND_INSERT) && !full;
  assign ctl.pop_en = accept && (in_ch.kind == KIND_POP) && !empty;
  assign ctl.value  = in_ch.value;

  // the chain of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                     l_ge;
    logic signed [DATA_W-1:0] l_entry;
    logic signed [DATA_W-1:0] r_entry;

    assign occ[i]    = (CNT_W'(i) < count_r);
    assign eq_vec[i] = stat[i].eq;

    if (i == 0) begin : g_first
      assign l_ge    = 1'b0;
      assign l_entry = ctl.value;
    end else begin : g_mid
      assign l_ge    = stat[i-1].ge;
      assign l_entry = entry[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign r_entry = entry[i];
    end else begin : g_inner
      assign r_entry = entry[i+1];
    end

    siq_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .occupied    (occ[i]),
      .left_ge     (l_ge),
      .left_entry  (l_entry),
      .right_entry (r_entry),
      .entry       (entry[i]),
      .stat        (stat[i])
    );
  end

  assign found = |eq_vec;

  // result and count update
  always_comb begin
    count_nxt     = count_r;
    out_ok_nxt    = 1'b0;
    out_value_nxt = '0;
    unique case (in_ch.kind)
      KIND_INSERT: begin
        out_ok_nxt = !full;
        if (!full) count_nxt = count_r + CNT_W'(1);
      end
      KIND_POP: begin
        out_ok_nxt = !empty;
        if (!empty) begin
          count_nxt     = count_r - CNT_W'(1);
          out_value_nxt = entry[0];
        end
      end
      KIND_FIND: begin
        out_ok_nxt = found;
      end
      KIND_CLEAR: begin
        out_ok_nxt = 1'b1;
        count_nxt  = '0;
      end
      default: begin
        out_ok_nxt = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_ok_r    <= out_ok_nxt;
      out_value_r <= out_value_nxt;
      out_count_r <= OUT_CNT_W'(count_nxt);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.ok           = out_ok_r;
  assign out_ch.result_value = out_value_r;
  assign out_ch.count        = out_count_r;

  // ascending order holds across all occupied neighbors
  logic sorted_ok;
  always_comb begin
    sorted_ok = 1'b1;
    for (int k = 0; k < CAPACITY - 1; k++) begin
      if (occ[k+1] && (entry[k] > entry[k+1])) sorted_ok = 1'b0;
    end
  end

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    sorted_ok)
    else $error("chain lost ascending order");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_ch.kind == KIND_POP) && !empty) |=>
      (count_r == $past(count_r) - CNT_W'(1)))
    else $error("pop did not lower the count by one");

  a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_ch.kind == KIND_CLEAR)) |=>
      (out_valid_r && out_ok_r && (count_r == '0)))
    else $error("clear did not empty the queue");
`endif

endmodule

// File: src/siq_cell.sv
// one cell of the sorted chain: holds a single entry, shifts right on insert
// and left on pop; depends on siq_pkg
module siq_cell import siq_pkg::*; (
  input  logic                     clk,
  input  siq_ctl_t                 ctl,
  input  logic                     occupied,
  input  logic                     left_ge,
  input  logic signed [DATA_W-1:0] left_entry,
  input  logic signed [DATA_W-1:0] right_entry,
  output logic signed [DATA_W-1:0] entry,
  output siq_stat_t                stat
);

  logic signed [DATA_W-1:0] entry_r;
  logic signed [DATA_W-1:0] entry_nxt;

  // an empty cell counts as greater than any value so inserts land there
  assign stat.ge = !occupied || (entry_r >= ctl.value);
  assign stat.eq = occupied && (entry_r == ctl.value);
  assign entry   = entry_r;

  // insert: first ge cell takes the new value, later ones take the left entry
  always_comb begin
    entry_nxt = entry_r;
    if (ctl.ins_en && stat.ge) begin
      entry_nxt = left_ge ? left_entry : ctl.value;
    end else if (ctl.pop_en) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

// File: sim/sorted_insert_priority_queue_top_tb.sv
// self-checking testbench for sorted_insert_priority_queue_top: a directed script, then
// random insert/pop/find/clear traffic checked against a behavioral sorted-store model
// depends on siq_pkg, siq_if and the sorted_insert_priority_queue_top rtl
module sorted_insert_priority_queue_top_tb import siq_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  // one reply as the block reports it
  typedef struct packed {
    logic                     ok;
    logic signed [DATA_W-1:0] result_value;
    logic [OUT_CNT_W-1:0]     count;
  } queue_reply_t;

  // one line of the opening script; typed rows carry their reply inline
  typedef struct {
    logic [KIND_W-1:0]        kind;
    logic signed [DATA_W-1:0] value;
    bit                       typed;
    logic                     ok;
    logic signed [DATA_W-1:0] result_value;
    logic [OUT_CNT_W-1:0]     count;
  } script_row_t;

  localparam int SCRIPT_LEN   = 24;
  localparam int RANDOM_ITEMS = 1200;

  logic clk = 1'b0;
  logic rst_n;

  siq_in_if  in_ch ();
  siq_out_if out_ch ();

  sorted_insert_priority_queue_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #1 clk = ~clk;

  // behavioral copy of the sorted store
  logic signed [DATA_W-1:0] sorted_store [CAPACITY];
  int unsigned              stored = 0;

  queue_reply_t pending_replies [$];
  int unsigned  mismatch_count = 0;
  bit           send_steady    = 1'b0;
  bit           drain_steady   = 1'b0;

  // fill to capacity through extremes and duplicates, then exercise the full store
  script_row_t opening_script [SCRIPT_LEN] = '{
    '{KIND_POP,    32'sd0,        1'b1, 1'b0, 32'sd0,        5'd0},
    '{KIND_FIND,   32'sd0,        1'b1, 1'b0, 32'sd0,        5'd0},
    '{KIND_INSERT, 32'h7fff_ffff, 1'b1, 1'b1, 32'sd0,        5'd1},
    '{KIND_INSERT, 32'h8000_0000, 1'b1, 1'b1, 32'sd0,        5'd2},
    '{KIND_INSERT, 32'sd0,        1'b1, 1'b1, 32'sd0,        5'd3},
    '{KIND_INSERT, -32'sd1,       1'b1, 1'b1, 32'sd0,        5'd4},
    '{KIND_INSERT, 32'sd0,        1'b1, 1'b1, 32'sd0,        5'd5},
    '{KIND_INSERT, 32'sd1,        1'b0, 1'b0, 32'sd0,        5'd0},
    '{KIND_INSERT, 32'h7fff_ffff, 1'b1, 1'b1, 32'sd0,        5'd7},
    '{KIND_INSERT, 32'h8000_0000, 1'b1, 1'b1, 32'sd0,        5'd8},
    '{KIND_INSERT, 32'sd100,      1'b0, 1'b0, 32'sd0,        5'd0},
    '{KIND_INSERT, -32'sd100,     1'b0, 1'b0, 32'sd0,        5'd0},
    '{KIND_INSERT, 32'h5555_5555, 1'b0, 1'b0, 32'sd0,        5'd0},
    '{KIND_INSERT, 32'haaaa_aaaa, 1'b0, 1'b0, 32'sd0,        5'd0},
    '{KIND_INSERT, 32'sd42,       1'b0, 1'b0, 32'sd0,        5'd0},
    '{KIND_INSERT, 32'sd7,        1'b0, 1'b0, 32'sd0,        5'd0},
    '{KIND_INSERT, -32'sd7,       1'b0, 1'b0, 32'sd0,        5'd0},
    '{KIND_INSERT, 32'h1234_5678, 1'b1, 1'b1, 32'sd0,        5'd16},
    '{KIND_INSERT, 32'sd5,        1'b1, 1'b0, 32'sd0,        5'd16},
    '{KIND_FIND,   32'h7fff_ffff, 1'b1, 1'b1, 32'sd0,        5'd16},
    '{KIND_FIND,   32'sd3,        1'b1, 1'b0, 32'sd0,        5'd16},
    '{KIND_POP,    32'sd0,        1'b1, 1'b1, 32'h8000_0000, 5'd15},
    '{KIND_CLEAR,  32'sd0,        1'b1, 1'b1, 32'sd0,        5'd0},
    '{KIND_CLEAR,  32'sd0,        1'b1, 1'b1, 32'sd0,        5'd0}
  };

  // apply one request to the sorted store and return the reply it yields
  function automatic queue_reply_t apply_request(input logic [KIND_W-1:0] kind,
                                                 input logic signed [DATA_W-1:0] value);
    queue_reply_t reply;
    int unsigned  pos;
    reply = '0;
    case (kind)
      KIND_INSERT: begin
        if (stored < CAPACITY) begin
          pos = stored;
          for (int i = 0; i < stored; i++) begin
            if (pos == stored && sorted_store[i] >= value) pos = i;
          end
          for (int i = stored; i > pos; i--) sorted_store[i] = sorted_store[i-1];
          sorted_store[pos] = value;
          stored++;
          reply.ok = 1'b1;
        end
      end
      KIND_POP: begin
        if (stored > 0) begin
          reply.result_value = sorted_store[0];
          for (int i = 1; i < stored; i++) sorted_store[i-1] = sorted_store[i];
          stored--;
          reply.ok = 1'b1;
        end
      end
      KIND_FIND: begin
        for (int i = 0; i < stored; i++) begin
          if (sorted_store[i] == value) reply.ok = 1'b1;
        end
      end
      default: begin
        stored = 0;
        reply.ok = 1'b1;
      end
    endcase
    reply.count = OUT_CNT_W'(stored);
    return reply;
  endfunction

  // wait before an item or a result; steady stretches draw no wait
  function automatic int unsigned draw_wait(input bit steady);
    return steady ? 0 : $urandom_range(0, 13);
  endfunction

  // values lean toward small numbers, extremes and stored entries so finds hit
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $signed(DATA_W'($urandom_range(0, 8))) - 4;
      2: return (stored > 0) ? sorted_store[$urandom_range(0, stored - 1)] : $urandom;
      default: begin
        case ($urandom_range(0, 3))
          0: return {1'b1, {(DATA_W-1){1'b0}}};
          1: return {1'b0, {(DATA_W-1){1'b1}}};
          2: return '0;
          default: return '1;
        endcase
      end
    endcase
  endfunction

  task automatic flag_mismatch(input string what);
    $display("%0t ns mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  // drive one request and return at the edge that accepts it
  task automatic push_request(input logic [KIND_W-1:0] kind,
                              input logic signed [DATA_W-1:0] value);
    int unsigned gap;
    bit          took;
    if ($urandom_range(0, 39) == 0) send_steady = !send_steady;
    gap = draw_wait(send_steady);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind  <= kind;
    in_ch.value <= value;
    do begin
      @(negedge clk);
      took = in_ch.ready;
      @(posedge clk);
    end while (!took);
  endtask

  // stimulus: reset, opening script, then random traffic
  initial begin
    int unsigned              insert_pct;
    int unsigned              roll;
    logic [KIND_W-1:0]        kind;
    logic signed [DATA_W-1:0] value;
    queue_reply_t             reply;
    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.kind  <= KIND_INSERT;
    in_ch.value <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (opening_script[r]) begin
      push_request(opening_script[r].kind, opening_script[r].value);
      reply = apply_request(opening_script[r].kind, opening_script[r].value);
      if (opening_script[r].typed)
        reply = '{opening_script[r].ok, opening_script[r].result_value,
                  opening_script[r].count};
      pending_replies.push_back(reply);
    end

    // random traffic; insert share drifts so the store swings between empty and full
    insert_pct = 50;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) begin
        case ($urandom_range(0, 2))
          0: insert_pct = 25;
          1: insert_pct = 48;
          default: insert_pct = 72;
        endcase
      end
      roll = $urandom_range(0, 99);
      if (roll < 3) kind = KIND_CLEAR;
      else if (roll < 3 + insert_pct) kind = KIND_INSERT;
      else if (roll[0]) kind = KIND_POP;
      else kind = KIND_FIND;
      value = pick_value();
      push_request(kind, value);
      pending_replies.push_back(apply_request(kind, value));
    end
    in_ch.valid <= 1'b0;

    // drain the remaining replies, then allow for stragglers
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("sorted_insert_priority_queue_top_tb: clean");
    end else begin
      $display("sorted_insert_priority_queue_top_tb: errors");
    end
    $finish;
  end

  // result side: random stalls, one draw per reply
  initial begin
    int unsigned stall;
    bit          took;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      if ($urandom_range(0, 39) == 0) drain_steady = !drain_steady;
      stall = draw_wait(drain_steady);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do begin
        @(negedge clk);
        took = out_ch.valid;
        @(posedge clk);
      end while (!took);
    end
  end

  // reply check, sampled mid-cycle while the handshake is stable
  always @(negedge clk) begin
    queue_reply_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_replies.size() == 0) begin
        flag_mismatch("reply with no request outstanding");
      end else begin
        want = pending_replies.pop_front();
        if (out_ch.ok !== want.ok)
          flag_mismatch($sformatf("ok %b, want %b", out_ch.ok, want.ok));
        if (out_ch.result_value !== want.result_value)
          flag_mismatch($sformatf("result_value %0d, want %0d",
                                  out_ch.result_value, want.result_value));
        if (out_ch.count !== want.count)
          flag_mismatch($sformatf("count %0d, want %0d", out_ch.count, want.count));
      end
    end
  end

  // hang guard
  initial begin
    #1000000;
    $display("sorted_insert_priority_queue_top_tb: errors");
    $finish;
  end

endmodule
